/* rtl/bsp_schedule_cost_evaluator_unit_macros.svh */
// Assertion macros for the schedule cost evaluator checker.
// Uses clk_i and rst_ni from the module that expands them.
`ifndef BSP_SCHEDULE_COST_EVALUATOR_UNIT_MACROS_SVH
`define BSP_SCHEDULE_COST_EVALUATOR_UNIT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define BSP_SCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define BSP_SCE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

/* rtl/bsp_sce_pkg.sv */
// Shared types and constants of the schedule cost evaluator.
// No dependencies.
package bsp_sce_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [4:0]  NUM_PROCS_RST = 5'd16;
  localparam logic [6:0]  NUM_STEPS_RST = 7'd64;
  localparam logic [15:0] COMM_GAIN_RST = 16'd1;
  localparam logic [15:0] SYNC_COST_RST = 16'd0;

  typedef enum logic [1:0] {
    CMD_NODE = 2'd0,
    CMD_COMM = 2'd1,
    CMD_EVAL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_NUM_PROCS = 2'd0,
    CFG_NUM_STEPS = 2'd1,
    CFG_COMM_GAIN = 2'd2,
    CFG_SYNC_COST = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  superstep;
    logic [3:0]  proc_a;
    logic [3:0]  proc_b;
    logic [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_cost;
    logic [31:0] work_cost;
    logic [31:0] comm_cost;
    logic        rejected;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rmw;
    logic sweep_en;
    logic sweep_acc;
    logic sweep_start;
    logic fin_mul;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic rec_ok;
    logic sweep_last;
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/bsp_sce_chan_if.sv */
// Valid/ready channel carrying one payload transaction per handshake.
// Payload type is set by the instantiating level.
interface bsp_sce_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bsp_sce_ctrl.sv */
// Controller state machine of the schedule cost evaluator.
// Depends on bsp_sce_pkg; drives commands to bsp_sce_dp.
module bsp_sce_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bsp_sce_pkg::dp_status_t status_i,
  output bsp_sce_pkg::ctrl_cmd_t  cmd_o
);
  import bsp_sce_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RMW   = 7'b0000100,
    ST_SWEEP = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.cmd inside {CMD_NODE, CMD_COMM}) begin
            if (status_i.rec_ok) begin
              state_d = ST_RMW;
            end
          end else if (status_i.cmd == CMD_EVAL) begin
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_SWEEP;
          end
        end
      end
      ST_RMW: begin
        cmd_o.rmw = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.sweep_en  = 1'b1;
        cmd_o.sweep_acc = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.fin_mul = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/bsp_sce_dp.sv */
// Datapath of the schedule cost evaluator: config registers, table memories,
// sweep counters, max/sum pipeline and result register. Depends on bsp_sce_pkg.
module bsp_sce_dp #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_STEPS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bsp_sce_pkg::in_item_t               in_item_i,
  input  logic                                cfg_we_i,
  input  logic [bsp_sce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsp_sce_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  bsp_sce_pkg::ctrl_cmd_t              cmd_i,
  output bsp_sce_pkg::dp_status_t             status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output bsp_sce_pkg::out_item_t              out_item_o
);
  import bsp_sce_pkg::*;

  localparam int DEPTH = MAX_STEPS * MAX_PROCS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int UW    = $clog2(MAX_STEPS + 1);
  localparam int SYW   = 16 + UW;
  localparam logic [SW-1:0] STEP_LAST = SW'(MAX_STEPS - 1);
  localparam logic [PW-1:0] PROC_LAST = PW'(MAX_PROCS - 1);

  logic [4:0]  num_procs_q;
  logic [6:0]  num_steps_q;
  logic [15:0] comm_gain_q;
  logic [15:0] sync_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_procs_q <= NUM_PROCS_RST;
      num_steps_q <= NUM_STEPS_RST;
      comm_gain_q <= COMM_GAIN_RST;
      sync_cost_q <= SYNC_COST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_PROCS: num_procs_q <= cfg_data_i[4:0];
        CFG_NUM_STEPS: num_steps_q <= cfg_data_i[6:0];
        CFG_COMM_GAIN: comm_gain_q <= cfg_data_i;
        CFG_SYNC_COST: sync_cost_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [6:0] proc_lim;
  logic [8:0] step_lim;

  assign proc_lim = (7'(num_procs_q) < 7'(MAX_PROCS)) ? 7'(num_procs_q) : 7'(MAX_PROCS);
  assign step_lim = (9'(num_steps_q) < 9'(MAX_STEPS)) ? 9'(num_steps_q) : 9'(MAX_STEPS);

  // Input decode and range check
  cmd_e        in_cmd;
  logic        is_rec, rec_ok, rec_go;
  logic [8:0]  in_step_ext;
  logic [SW-1:0] in_step_idx;
  logic [15:0] in_base, in_addr_a, in_addr_b;

  assign in_cmd      = cmd_e'(in_item_i.cmd);
  assign is_rec      = (in_cmd == CMD_NODE) || (in_cmd == CMD_COMM);
  assign rec_ok      = (9'(in_item_i.superstep) < step_lim)
                     && (7'(in_item_i.proc_a) < proc_lim)
                     && ((in_cmd != CMD_COMM) || (7'(in_item_i.proc_b) < proc_lim));
  assign rec_go      = cmd_i.accept && is_rec && rec_ok;
  assign in_step_ext = 9'(in_item_i.superstep);
  assign in_step_idx = in_step_ext[SW-1:0];
  assign in_base     = 16'(in_item_i.superstep) * 16'(MAX_PROCS);
  assign in_addr_a   = in_base + 16'(in_item_i.proc_a);
  assign in_addr_b   = in_base + 16'(in_item_i.proc_b);

  cmd_e        rec_cmd_q;
  logic [AW-1:0] addr_a_q, addr_b_q;
  logic [15:0] weight_q;

  always_ff @(posedge clk_i) begin
    if (rec_go) begin
      rec_cmd_q <= in_cmd;
      addr_a_q  <= in_addr_a[AW-1:0];
      addr_b_q  <= in_addr_b[AW-1:0];
      weight_q  <= in_item_i.weight;
    end
  end

  // Sweep counters
  logic [SW-1:0] s_cnt_q;
  logic [PW-1:0] p_cnt_q;
  logic          sweep_last;
  logic [15:0]   sweep_full;
  logic [AW-1:0] sweep_addr;

  assign sweep_last = (s_cnt_q == STEP_LAST) && (p_cnt_q == PROC_LAST);
  assign sweep_full = 16'(s_cnt_q) * 16'(MAX_PROCS) + 16'(p_cnt_q);
  assign sweep_addr = sweep_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_cnt_q <= '0;
      p_cnt_q <= '0;
    end else if (cmd_i.sweep_en) begin
      if (p_cnt_q == PROC_LAST) begin
        p_cnt_q <= '0;
        s_cnt_q <= (s_cnt_q == STEP_LAST) ? '0 : s_cnt_q + SW'(1);
      end else begin
        p_cnt_q <= p_cnt_q + PW'(1);
      end
    end
  end

  // Table memories: read-first, zeroed on sweep
  logic [31:0] work_mem [DEPTH];
  logic [31:0] send_mem [DEPTH];
  logic [31:0] recv_mem [DEPTH];
  logic [31:0] work_rd_q, send_rd_q, recv_rd_q;
  logic          rd_en, work_we, send_we, recv_we;
  logic [AW-1:0] rd_a, rd_b, wr_a, wr_b;
  logic [31:0]   work_wd, send_wd, recv_wd;

  assign rd_en   = rec_go || cmd_i.sweep_en;
  assign rd_a    = cmd_i.sweep_en ? sweep_addr : in_addr_a[AW-1:0];
  assign rd_b    = cmd_i.sweep_en ? sweep_addr : in_addr_b[AW-1:0];
  assign wr_a    = cmd_i.sweep_en ? sweep_addr : addr_a_q;
  assign wr_b    = cmd_i.sweep_en ? sweep_addr : addr_b_q;
  assign work_we = cmd_i.sweep_en || (cmd_i.rmw && (rec_cmd_q == CMD_NODE));
  assign send_we = cmd_i.sweep_en || (cmd_i.rmw && (rec_cmd_q == CMD_COMM));
  assign recv_we = send_we;
  assign work_wd = cmd_i.sweep_en ? '0 : work_rd_q + 32'(weight_q);
  assign send_wd = cmd_i.sweep_en ? '0 : send_rd_q + 32'(weight_q);
  assign recv_wd = cmd_i.sweep_en ? '0 : recv_rd_q + 32'(weight_q);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      work_rd_q <= work_mem[rd_a];
    end
    if (work_we) begin
      work_mem[wr_a] <= work_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      send_rd_q <= send_mem[rd_a];
    end
    if (send_we) begin
      send_mem[wr_a] <= send_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      recv_rd_q <= recv_mem[rd_b];
    end
    if (recv_we) begin
      recv_mem[wr_b] <= recv_wd;
    end
  end

  // Used supersteps and sticky reject
  logic [MAX_STEPS-1:0] step_used_q;
  logic                 reject_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_used_q <= '0;
      reject_q    <= 1'b0;
    end else if (cmd_i.out_load) begin
      step_used_q <= '0;
      reject_q    <= 1'b0;
    end else if (cmd_i.accept && is_rec) begin
      if (!rec_ok) begin
        reject_q <= 1'b1;
      end else if (in_cmd == CMD_NODE) begin
        step_used_q[in_step_idx] <= 1'b1;
      end
    end
  end

  // Stage 1 tags
  logic          t1_valid_q;
  logic          t1_in_q, t1_last_q, t1_step_ok_q;
  logic [SW-1:0] t1_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else begin
      t1_valid_q <= cmd_i.sweep_en && cmd_i.sweep_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_step_ok_q <= 9'(s_cnt_q) < step_lim;
    t1_in_q      <= (9'(s_cnt_q) < step_lim) && (7'(p_cnt_q) < proc_lim);
    t1_last_q    <= (p_cnt_q == PROC_LAST);
    t1_step_q    <= s_cnt_q;
  end

  // Row maxima and sums
  logic [31:0] work_v, send_v, recv_v, comm_v, mw_nx, mc_nx;
  logic        row_used_w;
  logic [31:0] mw_q, mc_q, row_w_q, row_c_q, work_sum_q, comm_sum_q;
  logic        row_v_q, row_used_q;
  logic [UW-1:0] used_cnt_q;

  assign work_v     = t1_in_q ? work_rd_q : '0;
  assign send_v     = t1_in_q ? send_rd_q : '0;
  assign recv_v     = t1_in_q ? recv_rd_q : '0;
  assign comm_v     = (send_v > recv_v) ? send_v : recv_v;
  assign mw_nx      = (work_v > mw_q) ? work_v : mw_q;
  assign mc_nx      = (comm_v > mc_q) ? comm_v : mc_q;
  assign row_used_w = t1_step_ok_q && step_used_q[t1_step_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_v_q    <= 1'b0;
      row_used_q <= 1'b0;
      mw_q       <= '0;
      mc_q       <= '0;
      row_w_q    <= '0;
      row_c_q    <= '0;
      work_sum_q <= '0;
      comm_sum_q <= '0;
      used_cnt_q <= '0;
    end else if (cmd_i.sweep_start) begin
      row_v_q    <= 1'b0;
      mw_q       <= '0;
      mc_q       <= '0;
      work_sum_q <= '0;
      comm_sum_q <= '0;
      used_cnt_q <= '0;
    end else begin
      row_v_q <= t1_valid_q && t1_last_q;
      if (t1_valid_q) begin
        if (t1_last_q) begin
          row_w_q    <= mw_nx;
          row_c_q    <= mc_nx;
          row_used_q <= row_used_w;
          mw_q       <= '0;
          mc_q       <= '0;
        end else begin
          mw_q <= mw_nx;
          mc_q <= mc_nx;
        end
      end
      if (row_v_q) begin
        work_sum_q <= work_sum_q + row_w_q;
        comm_sum_q <= comm_sum_q + row_c_q;
        used_cnt_q <= used_cnt_q + UW'(row_used_q);
      end
    end
  end

  // Final products and result register
  logic [47:0]    gc_full;
  logic [UW-1:0]  used_m1;
  logic [SYW-1:0] sync_full;
  logic [31:0]    gc_q, sync_q;

  assign gc_full   = 48'(comm_gain_q) * 48'(comm_sum_q);
  assign used_m1   = used_cnt_q - UW'(1);
  assign sync_full = SYW'(sync_cost_q) * SYW'(used_m1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_mul) begin
      gc_q   <= gc_full[31:0];
      sync_q <= (used_cnt_q != '0) ? 32'(sync_full) : '0;
    end
  end

  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.total_cost <= work_sum_q + gc_q + sync_q;
      out_item_q.work_cost  <= work_sum_q;
      out_item_q.comm_cost  <= comm_sum_q;
      out_item_q.rejected   <= reject_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.cmd        = in_cmd;
  assign status_o.rec_ok     = rec_ok;
  assign status_o.sweep_last = sweep_last;
  assign status_o.pipe_empty = !t1_valid_q && !row_v_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

/* rtl/bsp_schedule_cost_evaluator_unit.sv */
// Top level of the BSP schedule cost evaluator.
// Depends on bsp_sce_pkg, bsp_sce_chan_if, bsp_sce_ctrl and bsp_sce_dp.
//
// Node and communication records are read from their table memory, which has
// separate read and write ports, in the accept cycle and written back with
// the added weight in the next. An evaluate walks every table entry one per
// cycle, reading and zeroing it, then drains the pipeline and forms the two
// products; the next input is taken once the result register is loaded.
// After reset the same walk clears the tables, so no input is taken until it
// ends (configuration writes are taken at any time). Out-of-range records
// are dropped in the accept cycle and set the reject flag reported with the
// next result.
module bsp_schedule_cost_evaluator_unit #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_STEPS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  bsp_sce_chan_if.sink                       in_i,
  bsp_sce_chan_if.source                     out_o,
  input  logic                               cfg_we_i,
  input  logic [bsp_sce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsp_sce_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bsp_sce_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;

  bsp_sce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  bsp_sce_dp #(
    .MAX_PROCS (MAX_PROCS),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_item;

endmodule

/* rtl/bsp_sce_chk.sv */
// Port-level checker for the schedule cost evaluator, bound to the top level.
// Depends on bsp_sce_pkg and bsp_schedule_cost_evaluator_unit_macros.svh.
`include "bsp_schedule_cost_evaluator_unit_macros.svh"

module bsp_sce_chk (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic [1:0]             in_cmd_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input bsp_sce_pkg::out_item_t out_item_i
);
  import bsp_sce_pkg::*;

  `BSP_SCE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `BSP_SCE_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_item_i))
  `BSP_SCE_ASSERT_NEXT(a_eval_busy, in_valid_i && in_ready_i && (in_cmd_i == CMD_EVAL), (!in_ready_i ##1 !in_ready_i))
  `BSP_SCE_ASSERT_SAME(a_result_after_busy, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind bsp_schedule_cost_evaluator_unit bsp_sce_chk u_bsp_sce_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.data.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.data)
);

/* verif/tb_top.sv */
// Self-checking testbench for bsp_schedule_cost_evaluator_unit.
// Drives random and directed schedule records through the valid/ready channels
// and checks every cost result against a built-in predictor.
// Depends on bsp_sce_pkg, bsp_sce_chan_if and bsp_schedule_cost_evaluator_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsp_sce_pkg::*;

  localparam int MAX_PROCS      = 16;
  localparam int MAX_STEPS      = 64;
  localparam int TABLE_DEPTH    = MAX_PROCS * MAX_STEPS;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TIMEOUT_CYCLES = 10000000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 194;
  localparam int MAX_REPORTS    = 40;

  typedef struct {
    in_item_t item;
    bit       wait_drain;
  } pending_rec_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bsp_sce_chan_if #(.payload_t(in_item_t))  in_ch ();
  bsp_sce_chan_if #(.payload_t(out_item_t)) out_ch ();

  bsp_schedule_cost_evaluator_unit #(
    .MAX_PROCS(MAX_PROCS),
    .MAX_STEPS(MAX_STEPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state
  logic [31:0] work_load [TABLE_DEPTH];
  logic [31:0] send_load [TABLE_DEPTH];
  logic [31:0] recv_load [TABLE_DEPTH];
  bit          step_busy [MAX_STEPS];
  bit          dropped_seen;
  logic [4:0]  procs_reg;
  logic [6:0]  steps_reg;
  logic [15:0] gain_reg;
  logic [15:0] barrier_reg;

  pending_rec_t pending_items[$];
  out_item_t    expected_costs[$];

  int send_idle_pct;
  int recv_idle_pct;
  int items_accepted;
  int evals_accepted;
  int results_checked;
  int mismatches;
  int cycle_count;

  function automatic int unsigned proc_limit();
    return (procs_reg < MAX_PROCS) ? procs_reg : MAX_PROCS;
  endfunction

  function automatic int unsigned step_limit();
    return (steps_reg < MAX_STEPS) ? steps_reg : MAX_STEPS;
  endfunction

  task automatic clear_loads();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      work_load[i] = '0;
      send_load[i] = '0;
      recv_load[i] = '0;
    end
    for (int s = 0; s < MAX_STEPS; s++) begin
      step_busy[s] = 1'b0;
    end
    dropped_seen = 1'b0;
  endtask

  task automatic apply_schedule_item(input in_item_t it);
    int unsigned np;
    int unsigned ns;
    int unsigned ia;
    int unsigned ib;
    int unsigned used;
    logic [31:0] peak_work;
    logic [31:0] peak_comm;
    logic [31:0] work_sum;
    logic [31:0] comm_sum;
    logic [31:0] gain_term;
    logic [31:0] sync_term;
    out_item_t   res;
    np = proc_limit();
    ns = step_limit();
    ia = it.superstep * MAX_PROCS + it.proc_a;
    ib = it.superstep * MAX_PROCS + it.proc_b;
    case (it.cmd)
      CMD_NODE: begin
        if (it.superstep >= ns || it.proc_a >= np) begin
          dropped_seen = 1'b1;
        end else begin
          work_load[ia] = work_load[ia] + it.weight;
          step_busy[it.superstep] = 1'b1;
        end
      end
      CMD_COMM: begin
        if (it.superstep >= ns || it.proc_a >= np || it.proc_b >= np) begin
          dropped_seen = 1'b1;
        end else begin
          send_load[ia] = send_load[ia] + it.weight;
          recv_load[ib] = recv_load[ib] + it.weight;
        end
      end
      CMD_EVAL: begin
        work_sum = '0;
        comm_sum = '0;
        used = 0;
        for (int unsigned s = 0; s < ns; s++) begin
          peak_work = '0;
          peak_comm = '0;
          for (int unsigned p = 0; p < np; p++) begin
            if (work_load[s * MAX_PROCS + p] > peak_work) peak_work = work_load[s * MAX_PROCS + p];
            if (send_load[s * MAX_PROCS + p] > peak_comm) peak_comm = send_load[s * MAX_PROCS + p];
            if (recv_load[s * MAX_PROCS + p] > peak_comm) peak_comm = recv_load[s * MAX_PROCS + p];
          end
          work_sum = work_sum + peak_work;
          comm_sum = comm_sum + peak_comm;
          if (step_busy[s]) used++;
        end
        gain_term = gain_reg * comm_sum;
        sync_term = (used > 0) ? barrier_reg * (used - 1) : 32'd0;
        res.total_cost = work_sum + gain_term + sync_term;
        res.work_cost  = work_sum;
        res.comm_cost  = comm_sum;
        res.rejected   = dropped_seen;
        expected_costs = {expected_costs, res};
        clear_loads();
      end
      default: begin
      end
    endcase
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_NUM_PROCS: procs_reg   = data[4:0];
      CFG_NUM_STEPS: steps_reg   = data[6:0];
      CFG_COMM_GAIN: gain_reg    = data;
      CFG_SYNC_COST: barrier_reg = data;
      default: begin
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Size registers carry random upper bits that the block must ignore.
  task automatic set_schedule_cfg(input int procs, input int steps, input int gain,
                                  input int barrier);
    write_reg(CFG_NUM_PROCS, 16'(($urandom & 16'hFFE0) | procs[4:0]));
    write_reg(CFG_NUM_STEPS, 16'(($urandom & 16'hFF80) | steps[6:0]));
    write_reg(CFG_COMM_GAIN, gain[15:0]);
    write_reg(CFG_SYNC_COST, barrier[15:0]);
  endtask

  task automatic queue_item(input in_item_t it, input bit wait_drain);
    pending_rec_t rec;
    rec.item       = it;
    rec.wait_drain = wait_drain;
    pending_items  = {pending_items, rec};
  endtask

  function automatic in_item_t mk_item(cmd_e c, logic [5:0] s, logic [3:0] a, logic [3:0] b,
                                       logic [15:0] w);
    in_item_t it;
    it.cmd       = c;
    it.superstep = s;
    it.proc_a    = a;
    it.proc_b    = b;
    it.weight    = w;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_costs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_item_t random_record();
    in_item_t    it;
    int unsigned np;
    int unsigned ns;
    int          r;
    int          pick;
    np = proc_limit();
    ns = step_limit();
    it = $urandom;
    r  = $urandom_range(0, 99);
    if (r < 3) begin
      it.cmd = CMD_NONE;
      return it;
    end
    it.cmd = ($urandom_range(0, 99) < 55) ? CMD_NODE : CMD_COMM;
    pick = $urandom_range(0, 99);
    if (pick < 20) it.weight = 16'hFFFF;
    else if (pick < 25) it.weight = 16'h0000;
    if (ns > 0 && np > 0) begin
      it.superstep = 6'($urandom_range(0, ns - 1));
      it.proc_a    = 4'($urandom_range(0, np - 1));
      if (it.cmd == CMD_COMM) it.proc_b = 4'($urandom_range(0, np - 1));
    end
    if (r < 11) begin
      pick = $urandom_range(0, 2);
      if (pick == 0 && ns < MAX_STEPS) it.superstep = 6'($urandom_range(ns, MAX_STEPS - 1));
      else if (pick == 1 && np < MAX_PROCS) it.proc_a = 4'($urandom_range(np, MAX_PROCS - 1));
      else if (np < MAX_PROCS) it.proc_b = 4'($urandom_range(np, MAX_PROCS - 1));
    end
    return it;
  endfunction

  task automatic fill_schedules(input int target);
    int       n;
    int       seq_len;
    bit       hold_next;
    in_item_t it;
    n = 0;
    hold_next = 1'b0;
    while (n < target) begin
      seq_len = $urandom_range(1, 40);
      for (int k = 0; k < seq_len; k++) begin
        it = random_record();
        queue_item(it, hold_next);
        hold_next = 1'b0;
        if (it.cmd != CMD_NONE) n++;
      end
      it = $urandom;
      it.cmd = CMD_EVAL;
      queue_item(it, 1'b0);
      n++;
      hold_next = ($urandom_range(0, 99) < 15);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    end
  endtask

  // Clock and reset
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    fork
      forever #5 clk_i = ~clk_i;
      begin
        repeat (6) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  // Input driver: hold a presented transaction until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid && in_ch.ready) begin
        apply_schedule_item(pending_items[0].item);
        if (pending_items[0].item.cmd == CMD_EVAL) evals_accepted++;
        pending_items.pop_front();
        items_accepted++;
      end
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          (!pending_items[0].wait_drain || expected_costs.size() == 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_items[0].item;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_costs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, out_ch.data);
          end
        end else begin
          want = expected_costs.pop_front();
          results_checked++;
          check_field("total_cost", want.total_cost, out_ch.data.total_cost);
          check_field("work_cost", want.work_cost, out_ch.data.work_cost);
          check_field("comm_cost", want.comm_cost, out_ch.data.comm_cost);
          check_field("rejected", 32'(want.rejected), 32'(out_ch.data.rejected));
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    items_accepted  = 0;
    evals_accepted  = 0;
    results_checked = 0;
    mismatches      = 0;
    cycle_count     = 0;
    procs_reg       = NUM_PROCS_RST;
    steps_reg       = NUM_STEPS_RST;
    gain_reg        = COMM_GAIN_RST;
    barrier_reg     = SYNC_COST_RST;
    clear_loads();
    @(posedge rst_ni);

    // Reset settings: field extremes, ignored fields, unknown command, empty evaluate.
    queue_item(mk_item(CMD_NODE, 6'd0, 4'd0, 4'd15, 16'hFFFF), 1'b0);
    queue_item(mk_item(CMD_NODE, 6'd63, 4'd15, 4'd0, 16'h0000), 1'b0);
    queue_item(mk_item(CMD_NODE, 6'd63, 4'd15, 4'd9, 16'h0007), 1'b0);
    queue_item(mk_item(CMD_COMM, 6'd0, 4'd0, 4'd15, 16'hFFFF), 1'b0);
    queue_item(mk_item(CMD_COMM, 6'd63, 4'd15, 4'd0, 16'h0001), 1'b0);
    queue_item(mk_item(CMD_NONE, 6'd63, 4'd15, 4'd15, 16'hFFFF), 1'b0);
    queue_item(mk_item(CMD_EVAL, 6'd42, 4'd10, 4'd5, 16'hA5A5), 1'b0);
    queue_item(mk_item(CMD_EVAL, 6'd0, 4'd0, 4'd0, 16'h0000), 1'b0);
    wait_drained();

    // Small sizes: drops on each field, product wrap, no used superstep.
    set_schedule_cfg(4, 8, 65535, 65535);
    queue_item(mk_item(CMD_NODE, 6'd8, 4'd0, 4'd0, 16'd5), 1'b0);
    queue_item(mk_item(CMD_COMM, 6'd1, 4'd0, 4'd4, 16'd5), 1'b0);
    queue_item(mk_item(CMD_COMM, 6'd1, 4'd4, 4'd0, 16'd5), 1'b0);
    queue_item(mk_item(CMD_NODE, 6'd2, 4'd3, 4'd12, 16'd100), 1'b0);
    queue_item(mk_item(CMD_COMM, 6'd3, 4'd1, 4'd2, 16'hFFFF), 1'b0);
    queue_item(mk_item(CMD_COMM, 6'd4, 4'd2, 4'd1, 16'hFFFF), 1'b0);
    queue_item(mk_item(CMD_EVAL, 6'd0, 4'd0, 4'd0, 16'h0000), 1'b0);
    queue_item(mk_item(CMD_COMM, 6'd0, 4'd0, 4'd3, 16'd1234), 1'b0);
    queue_item(mk_item(CMD_EVAL, 6'd63, 4'd15, 4'd15, 16'hFFFF), 1'b0);
    queue_item(mk_item(CMD_NODE, 6'd7, 4'd3, 4'd0, 16'd50), 1'b0);
    queue_item(mk_item(CMD_NODE, 6'd6, 4'd1, 4'd0, 16'd60), 1'b0);
    queue_item(mk_item(CMD_NODE, 6'd0, 4'd0, 4'd0, 16'd70), 1'b0);
    wait_drained();

    // Shrink sizes before the evaluate of records already stored.
    set_schedule_cfg(2, 2, 3, 10);
    queue_item(mk_item(CMD_EVAL, 6'd0, 4'd0, 4'd0, 16'h0000), 1'b0);
    wait_drained();

    // Zero sizes: every record dropped.
    set_schedule_cfg(0, 0, 1, 1);
    queue_item(mk_item(CMD_NODE, 6'd0, 4'd0, 4'd0, 16'd1), 1'b0);
    queue_item(mk_item(CMD_EVAL, 6'd0, 4'd0, 4'd0, 16'h0000), 1'b0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 61; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 61; end
        default: begin send_idle_pct = 11; recv_idle_pct = 11; end
      endcase
      case (ph)
        0: set_schedule_cfg(16, 64, 1, 0);
        1: set_schedule_cfg(1, 1, 65535, 65535);
        2: set_schedule_cfg(31, 127, 0, 65535);
        3: set_schedule_cfg(16, 64, 65535, 0);
        default: set_schedule_cfg($urandom_range(1, 16), $urandom_range(1, 64),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
      fill_schedules(PHASE_ITEMS);
      wait_drained();
    end

    $display("Ran %0d transactions with %0d evaluations across %0d size and stall phases",
             items_accepted, evals_accepted, NUM_PHASES);
    $display("Compared %0d cost results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
